@@ src/key_and_encoder_qualifier_top_macros.svh @@
// Assertion macros for the key and encoder qualifier.
// Included by key_and_encoder_qualifier_top.sv; depends on nothing else.
`ifndef KEY_AND_ENCODER_QUALIFIER_TOP_MACROS_SVH
`define KEY_AND_ENCODER_QUALIFIER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define KEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keq assertion failed (same cycle)");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define KEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keq assertion failed (next cycle)");

`endif

@@ src/keq_pkg.sv @@
// Shared types, constants and the button mapping for the key and encoder qualifier.
// No dependencies.
`default_nettype none

package keq_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [DELAY_W-1:0] DEFAULT_DELAY_MS = 16'd500;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_MUTE_BUZZ    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = 2'd2;

    // Key flag bits
    localparam logic [7:0] FLAG_UP   = 8'h01;
    localparam logic [7:0] FLAG_DOWN = 8'h02;
    localparam logic [7:0] FLAG_OK   = 8'h04;
    localparam logic [7:0] FLAG_BACK = 8'h08;

    typedef struct packed {
        logic [7:0]        buttons;
        logic              enc_a;
        logic              enc_b;
        logic              enc_key_n;
        logic              slide_switch;
        logic [TIME_W-1:0] now_ms;
        logic              options_mode;
        logic              clear_keys;
    } in_item_t;

    typedef struct packed {
        logic [7:0] key_flags_out;
        logic       buzz_request;
        logic       switch_state;
    } out_item_t;

    typedef struct packed {
        logic               mute_buzz;
        logic [DELAY_W-1:0] repeat_delay_ms;
        logic [DELAY_W-1:0] long_press_ms;
    } cfg_t;

    // Button byte to key flag byte
    function automatic logic [7:0] map_buttons(input logic [7:0] b);
        logic [7:0] f;
        f[0] = b[4]; // up
        f[1] = b[7]; // down
        f[2] = b[6]; // ok
        f[3] = b[5]; // back
        f[4] = b[1]; // jsl
        f[5] = b[2]; // jsr
        f[6] = b[0]; // l
        f[7] = b[3]; // r
        return f;
    endfunction

endpackage

`default_nettype wire

@@ src/keq_core.sv @@
// Per-poll key qualification: sticky flags, auto-repeat, encoder decode, long press.
// Depends on keq_pkg.
`default_nettype none

module keq_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire keq_pkg::in_item_t item,
    input  wire keq_pkg::cfg_t     cfg,
    output wire keq_pkg::out_item_t result
);

    logic [7:0]                   key_flags_reg, key_flags_next;
    logic                         buttons_held_reg, buttons_held_next;
    logic [keq_pkg::TIME_W-1:0]   repeat_deadline_reg, repeat_deadline_next;
    logic                         enc_a_last_reg;
    logic                         enc_key_last_reg;
    logic [keq_pkg::TIME_W-1:0]   press_deadline_reg, press_deadline_next;

    logic                         pressed;
    logic                         latch;
    logic                         enc_key;
    logic [7:0]                   flags;

    assign pressed = (item.buttons != 8'd0);
    assign enc_key = ~item.enc_key_n;
    assign latch   = pressed &&
                     (!buttons_held_reg || (item.now_ms >= repeat_deadline_reg));

    always_comb
    begin
        flags                = key_flags_reg;
        buttons_held_next    = buttons_held_reg;
        repeat_deadline_next = repeat_deadline_reg;
        press_deadline_next  = press_deadline_reg;

        if (item.clear_keys || item.options_mode)
        begin
            flags = 8'd0;
        end

        if (latch)
        begin
            flags = flags | keq_pkg::map_buttons(item.buttons);
        end

        if (!buttons_held_reg && pressed)
        begin
            buttons_held_next    = 1'b1;
            repeat_deadline_next = item.now_ms +
                {{(keq_pkg::TIME_W-keq_pkg::DELAY_W){1'b0}}, cfg.repeat_delay_ms};
        end
        else if (buttons_held_reg && !pressed)
        begin
            // release drops every flag
            flags             = 8'd0;
            buttons_held_next = 1'b0;
        end

        // falling edge on A: direction from B
        if (enc_a_last_reg && !item.enc_a)
        begin
            flags = flags | (item.enc_b ? keq_pkg::FLAG_DOWN : keq_pkg::FLAG_UP);
        end

        if (enc_key && !enc_key_last_reg)
        begin
            press_deadline_next = item.now_ms +
                {{(keq_pkg::TIME_W-keq_pkg::DELAY_W){1'b0}}, cfg.long_press_ms};
        end
        else if (!enc_key && enc_key_last_reg)
        begin
            flags = flags | ((item.now_ms < press_deadline_reg) ?
                             keq_pkg::FLAG_OK : keq_pkg::FLAG_BACK);
        end

        key_flags_next = flags;
    end

    assign result.key_flags_out = key_flags_next;
    assign result.buzz_request  = latch && item.options_mode && !cfg.mute_buzz;
    assign result.switch_state  = item.slide_switch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_flags_reg       <= 8'd0;
            buttons_held_reg    <= 1'b0;
            repeat_deadline_reg <= '0;
            enc_a_last_reg      <= 1'b0;
            enc_key_last_reg    <= 1'b0;
            press_deadline_reg  <= '0;
        end
        else if (step)
        begin
            key_flags_reg       <= key_flags_next;
            buttons_held_reg    <= buttons_held_next;
            repeat_deadline_reg <= repeat_deadline_next;
            enc_a_last_reg      <= item.enc_a;
            enc_key_last_reg    <= enc_key;
            press_deadline_reg  <= press_deadline_next;
        end
    end

endmodule

`default_nettype wire

@@ src/key_and_encoder_qualifier_top.sv @@
// Key and encoder qualifier: one poll in, one qualified key result out.
//
// Input channel (in_valid / in_stall / in_data) carries one poll per transfer:
// button byte, encoder A/B/key pins, slide switch, millisecond time stamp,
// options-mode flag and consumer clear. Output channel (out_valid / out_stall /
// out_data) returns the sticky key flags, a buzz request and the switch level,
// one result per poll, in order.
// Path: a poll accepted into the input register is processed by keq_core from there
// and its result is registered in the output register that drives out_valid/out_data.
// Throughput: one poll per cycle while out_stall does not hold; the flag and
// deadline registers are updated in the same cycle that a poll leaves the input
// register, so the next poll sees them at once.
// Stall: while out_valid is high and out_stall holds, the result register
// and the input register hold and in_stall rises once the input register is full.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready;
// write only while the block is idle. Index 3 is ignored.
// Reset: all key state clears, mute_buzz=0, both delays=500 ms, channels empty.
// Depends on keq_pkg, keq_core and key_and_encoder_qualifier_top_macros.svh.
`default_nettype none

`include "key_and_encoder_qualifier_top_macros.svh"

module key_and_encoder_qualifier_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output wire logic                          in_stall,
    input  wire keq_pkg::in_item_t             in_data,

    output wire logic                          out_valid,
    input  wire logic                          out_stall,
    output keq_pkg::out_item_t                 out_data,

    input  wire logic                          cfg_valid,
    output wire logic                          cfg_ready,
    input  wire logic [keq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [keq_pkg::DELAY_W-1:0]   cfg_data
);

    keq_pkg::cfg_t       cfg_reg;
    keq_pkg::in_item_t   in_item_reg;
    logic                in_valid_reg;
    keq_pkg::out_item_t  out_item_reg;
    logic                out_valid_reg;
    keq_pkg::out_item_t  result;

    logic                advance;
    logic                in_accept;
    logic                step;
    logic                buzz_shown;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign step      = in_valid_reg && advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign cfg_ready = 1'b1;

    assign buzz_shown = out_valid_reg && out_item_reg.buzz_request;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mute_buzz       <= 1'b0;
            cfg_reg.repeat_delay_ms <= keq_pkg::DEFAULT_DELAY_MS;
            cfg_reg.long_press_ms   <= keq_pkg::DEFAULT_DELAY_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                keq_pkg::REG_MUTE_BUZZ:    cfg_reg.mute_buzz       <= cfg_data[0];
                keq_pkg::REG_REPEAT_DELAY: cfg_reg.repeat_delay_ms <= cfg_data;
                keq_pkg::REG_LONG_PRESS:   cfg_reg.long_press_ms   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers: load on transfer only
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_data;
        end
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    keq_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    `KEQ_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, in_valid_reg)
    `KEQ_ASSERT_NEXT(a_step_gives_result, clk, rst_n, step, out_valid_reg)
    `KEQ_ASSERT_NOW(a_buzz_has_flags, clk, rst_n, buzz_shown, out_item_reg.key_flags_out != 8'd0)

endmodule

`default_nettype wire
